>>> rtl/lz_block_decompressor_macros.svh
// ----------------------------------------------------------------------------
// lz_block_decompressor_macros.svh
// Assertion macros used by the block decompressor RTL
// ----------------------------------------------------------------------------
`ifndef LZ_BLOCK_DECOMPRESSOR_MACROS_SVH
`define LZ_BLOCK_DECOMPRESSOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LZBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define LZBD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lzbd_pkg.sv
// ----------------------------------------------------------------------------
// lzbd_pkg
// Widths, codes and result type of the block decompressor
// ----------------------------------------------------------------------------
`default_nettype none

package lzbd_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int OPCODE_BITS = 2;
    localparam int KIND_BITS   = 3;
    localparam int ERR_BITS    = 2;
    localparam int NIB_BITS    = 4;
    localparam int CAP_BITS    = 32;
    localparam int TOTAL_BITS  = 32;
    localparam int OFFSET_BITS = 16;

    localparam int WINDOW_BYTES_DEF = 65536;
    localparam int COUNT_BITS_DEF   = 32;

    // result buffer behind the memory read stage
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS = OUT_PTR_BITS + 1;

    localparam logic [NIB_BITS-1:0]  LEN_ESCAPE = 4'hF;
    localparam logic [BYTE_BITS-1:0] EXT_MORE   = 8'hFF;
    localparam logic [NIB_BITS-1:0]  NIB_MASK   = 4'h0F;
    localparam logic [NIB_BITS-1:0]  MATCH_BASE = 4'd4;

    localparam logic [OPCODE_BITS-1:0] OP_PUSH    = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_TICK    = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_RESTART = 2'd2;
    localparam logic [OPCODE_BITS-1:0] OP_NOP     = 2'd3;

    localparam logic [KIND_BITS-1:0] K_NONE    = 3'd0;
    localparam logic [KIND_BITS-1:0] K_BYTE    = 3'd1;
    localparam logic [KIND_BITS-1:0] K_DONE    = 3'd2;
    localparam logic [KIND_BITS-1:0] K_ERROR   = 3'd3;
    localparam logic [KIND_BITS-1:0] K_REFUSED = 3'd4;

    localparam logic [ERR_BITS-1:0] E_NONE     = 2'd0;
    localparam logic [ERR_BITS-1:0] E_TRUNC    = 2'd1;
    localparam logic [ERR_BITS-1:0] E_OFFSET   = 2'd2;
    localparam logic [ERR_BITS-1:0] E_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [BYTE_BITS-1:0]  out_byte;
        logic [TOTAL_BITS-1:0] decoded_count;
        logic [ERR_BITS-1:0]   error_code;
    } t_out_item;

endpackage

`default_nettype wire

>>> rtl/lzbd_channels.sv
// ----------------------------------------------------------------------------
// lzbd channels
// Request and result channels of the block decompressor
// ----------------------------------------------------------------------------
`default_nettype none

interface lzbd_in_if import lzbd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OPCODE_BITS-1:0] opcode;
    logic [BYTE_BITS-1:0]   data_byte;
    logic                   last_byte;

    modport source (output valid, output opcode, output data_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input opcode, input data_byte, input last_byte,
                    output ready);
endinterface

interface lzbd_out_if import lzbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  kind;
    logic [BYTE_BITS-1:0]  out_byte;
    logic [TOTAL_BITS-1:0] decoded_count;
    logic [ERR_BITS-1:0]   error_code;

    modport source (output valid, output kind, output out_byte, output decoded_count,
                    output error_code, input ready);
    modport sink   (input valid, input kind, input out_byte, input decoded_count,
                    input error_code, output ready);
endinterface

`default_nettype wire

>>> rtl/lzbd_ram.sv
// ----------------------------------------------------------------------------
// lzbd_ram
// Simple dual-port RAM, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lzbd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [DATA_W-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [DATA_W-1:0]         o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/lz_block_decompressor.sv
// ----------------------------------------------------------------------------
// lz_block_decompressor
// LZ4-style block decoder fed one compressed byte or copy tick per request.
// i_in carries requests (push byte, copy tick, restart); o_out returns exactly
// one result per request, in order: nothing, decoded byte, done, error or
// refused push. i_cfg_wr_en/i_cfg_wr_data set the output capacity; the user is to
// write them only while idle, which the block leaves unchecked. Throughput: one
// request per cycle while ready is high, ticks and literals alike. Each request
// makes at most one read and one write of the history RAM, which sets this rate;
// a copy byte is forwarded when it is read in the cycle it is written. Path:
// history read stage, then the 4-entry result buffer, then o_out.
// Stall: the buffer plus the request in flight hold up to 4 results; ready
// then drops until a result is taken, and no result is lost or repeated.
// Reset: decoder state and the capacity (all ones) are set at once; history
// RAM is not cleared, since a match only reads bytes of the current block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lz_block_decompressor_macros.svh"

module lz_block_decompressor import lzbd_pkg::*; #(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_wr_en,
    input  wire [CAP_BITS-1:0]  i_cfg_wr_data,
    lzbd_in_if.sink             i_in,
    lzbd_out_if.source          o_out
);

    localparam int AW     = $clog2(WINDOW_BYTES);
    localparam int DIFF_W = OFFSET_BITS + 2;
    localparam int SUM_W  = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;

    localparam logic [3:0] PH_TOKEN     = 4'd0;
    localparam logic [3:0] PH_LIT_EXT   = 4'd1;
    localparam logic [3:0] PH_LITERALS  = 4'd2;
    localparam logic [3:0] PH_OFF_LO    = 4'd3;
    localparam logic [3:0] PH_OFF_HI    = 4'd4;
    localparam logic [3:0] PH_MATCH_EXT = 4'd5;
    localparam logic [3:0] PH_COPY      = 4'd6;
    localparam logic [3:0] PH_DONE      = 4'd7;
    localparam logic [3:0] PH_FAULT     = 4'd8;

    // decoder state
    logic [3:0]             r_phase,    n_phase;
    logic [NIB_BITS-1:0]    r_match_nib, n_match_nib;
    logic [COUNT_BITS-1:0]  r_run,      n_run;
    logic [BYTE_BITS-1:0]   r_off_lo,   n_off_lo;
    logic [OFFSET_BITS-1:0] r_offset,   n_offset;
    logic [TOTAL_BITS-1:0]  r_produced, n_produced;
    logic                   r_ended,    n_ended;
    logic [ERR_BITS-1:0]    r_fault,    n_fault;
    logic [AW-1:0]          r_wr_ptr,   n_wr_ptr;
    logic [CAP_BITS-1:0]    r_cap;

    // history read stage
    logic                   r_s1_valid;
    logic [KIND_BITS-1:0]   r_s1_kind,  n_s1_kind;
    logic [BYTE_BITS-1:0]   r_s1_lit;
    logic                   r_s1_copy,  n_s1_copy;
    logic                   r_s1_we,    n_s1_we;
    logic [AW-1:0]          r_s1_waddr;
    logic [TOTAL_BITS-1:0]  r_s1_count;
    logic [ERR_BITS-1:0]    r_s1_err,   n_s1_err;
    logic                   r_s1_fwd_hit, n_s1_fwd_hit;
    logic [BYTE_BITS-1:0]   r_s1_fwd_byte;

    // result buffer
    t_out_item               r_fifo [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] r_wr_idx, r_rd_idx;
    logic [OUT_CNT_BITS-1:0] r_count,  n_count;

    logic                   in_fire;
    logic                   out_fire;
    logic [BYTE_BITS-1:0]   ram_q;
    logic [BYTE_BITS-1:0]   s1_byte;
    t_out_item              s1_item;
    logic [AW-1:0]          rd_addr;
    logic [DIFF_W-1:0]      rd_diff;

    logic [NIB_BITS-1:0]    lit_nib;
    logic [NIB_BITS-1:0]    mat_nib;
    logic [COUNT_BITS:0]    ext_wide;
    logic [COUNT_BITS-1:0]  ext_run;
    logic [COUNT_BITS-1:0]  chk_len;
    logic [SUM_W-1:0]       chk_sum;
    logic                   over_cap;
    logic [OFFSET_BITS-1:0] off_val;
    logic                   off_bad;
    logic                   run_is_one;
    logic [AW-1:0]          wr_ptr_inc;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    // room for the request in flight plus everything buffered
    assign i_in.ready = (r_count + OUT_CNT_BITS'(r_s1_valid)) < OUT_CNT_BITS'(OUT_DEPTH);

    assign lit_nib = i_in.data_byte[7:4];
    assign mat_nib = i_in.data_byte[3:0] & NIB_MASK;

    // saturating add of an extension byte
    assign ext_wide = {1'b0, r_run} + (COUNT_BITS+1)'(i_in.data_byte);
    assign ext_run  = ext_wide[COUNT_BITS] ? '1 : ext_wide[COUNT_BITS-1:0];

    always_comb begin
        unique case (r_phase)
            PH_LIT_EXT, PH_MATCH_EXT: chk_len = ext_run;
            PH_OFF_HI:                chk_len = COUNT_BITS'(r_match_nib) + COUNT_BITS'(MATCH_BASE);
            default:                  chk_len = COUNT_BITS'(lit_nib);
        endcase
    end

    assign chk_sum  = SUM_W'(r_produced) + SUM_W'(chk_len);
    assign over_cap = chk_sum > SUM_W'(r_cap);

    assign off_val = {i_in.data_byte, r_off_lo};
    assign off_bad = (off_val == '0)
                  || (TOTAL_BITS'(off_val) > r_produced)
                  || ((OFFSET_BITS+1)'(off_val) > (OFFSET_BITS+1)'(WINDOW_BYTES));

    assign run_is_one = (r_run == COUNT_BITS'(1));
    assign wr_ptr_inc = (r_wr_ptr == AW'(WINDOW_BYTES - 1)) ? '0 : r_wr_ptr + AW'(1);

    // copy source = write pointer minus offset, wrapped into the window
    assign rd_diff = DIFF_W'(r_wr_ptr) - DIFF_W'(r_offset);
    assign rd_addr = rd_diff[DIFF_W-1] ? AW'(rd_diff + DIFF_W'(WINDOW_BYTES)) : AW'(rd_diff);

    // decode stage
    always_comb begin
        n_phase     = r_phase;
        n_match_nib = r_match_nib;
        n_run       = r_run;
        n_off_lo    = r_off_lo;
        n_offset    = r_offset;
        n_produced  = r_produced;
        n_ended     = r_ended;
        n_fault     = r_fault;
        n_wr_ptr    = r_wr_ptr;
        n_s1_kind   = K_NONE;
        n_s1_copy   = 1'b0;
        n_s1_we     = 1'b0;

        priority if (i_in.opcode == OP_RESTART) begin
            n_phase     = PH_TOKEN;
            n_match_nib = '0;
            n_run       = '0;
            n_off_lo    = '0;
            n_offset    = '0;
            n_produced  = '0;
            n_ended     = 1'b0;
            n_fault     = E_NONE;
            n_wr_ptr    = '0;
        end else if (i_in.opcode == OP_NOP) begin
            n_s1_kind = K_NONE;
        end else if (r_phase == PH_FAULT) begin
            n_s1_kind = K_ERROR;
        end else if (r_phase == PH_DONE) begin
            n_s1_kind = K_DONE;
        end else if (i_in.opcode == OP_TICK) begin
            if (r_phase == PH_COPY) begin
                n_s1_kind  = K_BYTE;
                n_s1_copy  = 1'b1;
                n_s1_we    = 1'b1;
                n_produced = r_produced + TOTAL_BITS'(1);
                n_wr_ptr   = wr_ptr_inc;
                n_run      = r_run - COUNT_BITS'(1);
                if (run_is_one) begin
                    n_phase = r_ended ? PH_DONE : PH_TOKEN;
                end
            end
        end else if (r_phase == PH_COPY) begin
            n_s1_kind = K_REFUSED;
        end else begin
            unique case (r_phase)
                PH_TOKEN: begin
                    n_match_nib = mat_nib;
                    if (lit_nib == LEN_ESCAPE) begin
                        if (i_in.last_byte) begin
                            n_phase = PH_FAULT; n_fault = E_TRUNC; n_s1_kind = K_ERROR;
                        end else begin
                            n_run   = COUNT_BITS'(LEN_ESCAPE);
                            n_phase = PH_LIT_EXT;
                        end
                    end else if (i_in.last_byte) begin
                        if (lit_nib != '0) begin
                            n_phase = PH_FAULT; n_fault = E_TRUNC; n_s1_kind = K_ERROR;
                        end else begin
                            n_phase   = PH_DONE;
                            n_s1_kind = K_DONE;
                        end
                    end else if (lit_nib == '0) begin
                        n_phase = PH_OFF_LO;
                    end else if (over_cap) begin
                        n_phase = PH_FAULT; n_fault = E_OVERFLOW; n_s1_kind = K_ERROR;
                    end else begin
                        n_run   = COUNT_BITS'(lit_nib);
                        n_phase = PH_LITERALS;
                    end
                end
                PH_LIT_EXT: begin
                    n_run = ext_run;
                    if (i_in.last_byte) begin
                        n_phase = PH_FAULT; n_fault = E_TRUNC; n_s1_kind = K_ERROR;
                    end else if (i_in.data_byte != EXT_MORE) begin
                        if (ext_run == '0) begin
                            n_phase = PH_OFF_LO;
                        end else if (over_cap) begin
                            n_phase = PH_FAULT; n_fault = E_OVERFLOW; n_s1_kind = K_ERROR;
                        end else begin
                            n_phase = PH_LITERALS;
                        end
                    end
                end
                PH_LITERALS: begin
                    if (i_in.last_byte && !run_is_one) begin
                        n_phase = PH_FAULT; n_fault = E_TRUNC; n_s1_kind = K_ERROR;
                    end else begin
                        n_s1_kind  = K_BYTE;
                        n_s1_we    = 1'b1;
                        n_produced = r_produced + TOTAL_BITS'(1);
                        n_wr_ptr   = wr_ptr_inc;
                        n_run      = r_run - COUNT_BITS'(1);
                        if (run_is_one) begin
                            n_phase = i_in.last_byte ? PH_DONE : PH_OFF_LO;
                        end
                    end
                end
                PH_OFF_LO: begin
                    if (i_in.last_byte) begin
                        n_phase = PH_FAULT; n_fault = E_TRUNC; n_s1_kind = K_ERROR;
                    end else begin
                        n_off_lo = i_in.data_byte;
                        n_phase  = PH_OFF_HI;
                    end
                end
                PH_OFF_HI: begin
                    n_offset = off_val;
                    // offset check ranks ahead of a missing extension byte
                    if (off_bad) begin
                        n_phase = PH_FAULT; n_fault = E_OFFSET; n_s1_kind = K_ERROR;
                    end else if (r_match_nib == LEN_ESCAPE) begin
                        if (i_in.last_byte) begin
                            n_phase = PH_FAULT; n_fault = E_TRUNC; n_s1_kind = K_ERROR;
                        end else begin
                            n_run   = COUNT_BITS'(LEN_ESCAPE) + COUNT_BITS'(MATCH_BASE);
                            n_phase = PH_MATCH_EXT;
                        end
                    end else if (over_cap) begin
                        n_phase = PH_FAULT; n_fault = E_OVERFLOW; n_s1_kind = K_ERROR;
                    end else begin
                        n_run   = COUNT_BITS'(r_match_nib) + COUNT_BITS'(MATCH_BASE);
                        n_ended = i_in.last_byte;
                        n_phase = PH_COPY;
                    end
                end
                PH_MATCH_EXT: begin
                    n_run = ext_run;
                    if (i_in.data_byte == EXT_MORE) begin
                        if (i_in.last_byte) begin
                            n_phase = PH_FAULT; n_fault = E_TRUNC; n_s1_kind = K_ERROR;
                        end
                    end else if (over_cap) begin
                        n_phase = PH_FAULT; n_fault = E_OVERFLOW; n_s1_kind = K_ERROR;
                    end else begin
                        n_ended = i_in.last_byte;
                        n_phase = PH_COPY;
                    end
                end
                default: begin
                    n_s1_kind = K_NONE;
                end
            endcase
        end
    end

    assign n_s1_err = (n_s1_kind == K_ERROR) ? n_fault : E_NONE;

    // history read stage: forward the byte being written when addresses meet
    assign s1_byte = r_s1_copy ? (r_s1_fwd_hit ? r_s1_fwd_byte : ram_q) : r_s1_lit;
    assign n_s1_fwd_hit = n_s1_copy && r_s1_valid && r_s1_we && (rd_addr == r_s1_waddr);

    lzbd_ram #(
        .DATA_W (BYTE_BITS),
        .DEPTH  (WINDOW_BYTES)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid && r_s1_we),
        .i_waddr (r_s1_waddr),
        .i_wdata (s1_byte),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        s1_item.kind          = r_s1_kind;
        s1_item.out_byte      = (r_s1_kind == K_BYTE) ? s1_byte : '0;
        s1_item.decoded_count = r_s1_count;
        s1_item.error_code    = r_s1_err;
    end

    assign n_count = r_count + OUT_CNT_BITS'(r_s1_valid) - OUT_CNT_BITS'(out_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TOKEN;
            r_match_nib <= '0;
            r_run       <= '0;
            r_off_lo    <= '0;
            r_offset    <= '0;
            r_produced  <= '0;
            r_ended     <= 1'b0;
            r_fault     <= E_NONE;
            r_wr_ptr    <= '0;
            r_cap       <= '1;
            r_s1_valid  <= 1'b0;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_phase     <= n_phase;
                r_match_nib <= n_match_nib;
                r_run       <= n_run;
                r_off_lo    <= n_off_lo;
                r_offset    <= n_offset;
                r_produced  <= n_produced;
                r_ended     <= n_ended;
                r_fault     <= n_fault;
                r_wr_ptr    <= n_wr_ptr;
            end
            r_s1_valid <= in_fire;
            if (r_s1_valid) begin
                r_wr_idx <= r_wr_idx + OUT_PTR_BITS'(1);
            end
            if (out_fire) begin
                r_rd_idx <= r_rd_idx + OUT_PTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_kind     <= n_s1_kind;
            r_s1_lit      <= i_in.data_byte;
            r_s1_copy     <= n_s1_copy;
            r_s1_we       <= n_s1_we;
            r_s1_waddr    <= r_wr_ptr;
            r_s1_count    <= n_produced;
            r_s1_err      <= n_s1_err;
            r_s1_fwd_hit  <= n_s1_fwd_hit;
            r_s1_fwd_byte <= s1_byte;
        end
        if (r_s1_valid) begin
            r_fifo[r_wr_idx] <= s1_item;
        end
    end

    assign o_out.valid         = (r_count != '0);
    assign o_out.kind          = r_fifo[r_rd_idx].kind;
    assign o_out.out_byte      = r_fifo[r_rd_idx].out_byte;
    assign o_out.decoded_count = r_fifo[r_rd_idx].decoded_count;
    assign o_out.error_code    = r_fifo[r_rd_idx].error_code;

    `LZBD_ASSERT_NXT(a_req_reaches_read_stage, i_clk, i_rst_n, in_fire, r_s1_valid, "request lost before read stage")
    `LZBD_ASSERT_IMP(a_buffer_bound, i_clk, i_rst_n, r_s1_valid, r_count < OUT_CNT_BITS'(OUT_DEPTH), "result buffer overrun")
    `LZBD_ASSERT_IMP(a_fwd_only_copy, i_clk, i_rst_n, r_s1_valid && r_s1_fwd_hit, r_s1_copy, "forward on a non-copy request")
    `LZBD_ASSERT_IMP(a_error_has_code, i_clk, i_rst_n, o_out.valid && (o_out.kind == K_ERROR), o_out.error_code != E_NONE, "error result without code")

endmodule

`default_nettype wire

>>> dv/lz_block_decompressor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_block_decompressor_test
// Drives compressed blocks, copy ticks, restarts and noise into the block
// decompressor under random gaps and output stalls. Every result is checked
// field by field against an in-bench decoder model, over several capacities.
// ----------------------------------------------------------------------------
module lz_block_decompressor_test;
    import lzbd_pkg::*;

    typedef struct packed {
        logic [OPCODE_BITS-1:0] op;
        logic [BYTE_BITS-1:0]   data;
        logic                   last;
    } t_lz_req;

    typedef enum logic [3:0] {
        ST_TOKEN, ST_LIT_EXT, ST_LITERALS, ST_OFF_LO, ST_OFF_HI,
        ST_MATCH_EXT, ST_COPY, ST_DONE, ST_FAULT
    } t_dec_state;

    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 64'd1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CAP_BITS-1:0] cfg_wr_data = '0;

    logic                   req_valid = 1'b0;
    logic [OPCODE_BITS-1:0] req_op = OP_NOP;
    logic [BYTE_BITS-1:0]   req_data = '0;
    logic                   req_last = 1'b0;
    logic                   res_ready = 1'b0;

    lzbd_in_if  in_ch ();
    lzbd_out_if out_ch ();

    assign in_ch.valid     = req_valid;
    assign in_ch.opcode    = req_op;
    assign in_ch.data_byte = req_data;
    assign in_ch.last_byte = req_last;
    assign out_ch.ready    = res_ready;

    lz_block_decompressor dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch.sink),
        .o_out         (out_ch.source)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder model state
    t_dec_state           dec_st;
    logic [NIB_BITS-1:0]  m_nib;
    logic [63:0]          run_left;
    logic [63:0]          produced;
    logic [63:0]          cap_reg;
    logic [7:0]           off_lo;
    logic [15:0]          m_off;
    bit                   in_ended;
    logic [ERR_BITS-1:0]  fault;
    logic [7:0]           hist_mem [0:WINDOW_BYTES_DEF-1];

    t_lz_req   req_q [$];
    t_lz_req   blk_q [$];
    t_out_item result_q [$];

    t_lz_req   cur_req;
    t_out_item want;
    t_out_item got;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          src_burst = 1'b0;
    bit          snk_burst = 1'b0;
    int unsigned err_cnt = 0;
    int unsigned rand_items = 0;

    function automatic void clear_decoder();
        dec_st   = ST_TOKEN;
        m_nib    = '0;
        run_left = '0;
        off_lo   = '0;
        m_off    = '0;
        produced = '0;
        in_ended = 1'b0;
        fault    = E_NONE;
    endfunction

    function automatic logic [KIND_BITS-1:0] raise_fault(input logic [ERR_BITS-1:0] code);
        dec_st = ST_FAULT;
        fault  = code;
        return K_ERROR;
    endfunction

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > COUNT_MAX) ? COUNT_MAX : s;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        hist_mem[int'(produced % 64'(WINDOW_BYTES_DEF))] = b;
        produced = produced + 64'd1;
    endfunction

    function automatic logic [KIND_BITS-1:0] open_literals(input logic [63:0] len);
        if (len == 0) begin
            dec_st = ST_OFF_LO;
            return K_NONE;
        end
        if (produced + len > cap_reg) return raise_fault(E_OVERFLOW);
        run_left = len;
        dec_st   = ST_LITERALS;
        return K_NONE;
    endfunction

    function automatic logic [KIND_BITS-1:0] open_copy(input logic [63:0] len, input bit lst);
        if (produced + len > cap_reg) return raise_fault(E_OVERFLOW);
        run_left = len;
        in_ended = lst;
        dec_st   = ST_COPY;
        return K_NONE;
    endfunction

    function automatic logic [KIND_BITS-1:0] take_byte(input logic [7:0] b, input bit lst,
                                                        output logic [7:0] ob);
        logic [63:0] lit;
        ob = '0;
        case (dec_st)
            ST_TOKEN: begin
                lit   = 64'(b[7:4]);
                m_nib = b[3:0] & NIB_MASK;
                if (b[7:4] == LEN_ESCAPE) begin
                    if (lst) return raise_fault(E_TRUNC);
                    run_left = lit;
                    dec_st   = ST_LIT_EXT;
                    return K_NONE;
                end
                if (lst) begin
                    if (lit > 0) return raise_fault(E_TRUNC);
                    dec_st = ST_DONE;
                    return K_DONE;
                end
                return open_literals(lit);
            end
            ST_LIT_EXT: begin
                run_left = sat_sum(run_left, 64'(b));
                if (lst) return raise_fault(E_TRUNC);
                if (b == EXT_MORE) return K_NONE;
                return open_literals(run_left);
            end
            ST_LITERALS: begin
                if (lst && run_left > 1) return raise_fault(E_TRUNC);
                emit_byte(b);
                ob = b;
                run_left = run_left - 64'd1;
                if (run_left == 0) dec_st = lst ? ST_DONE : ST_OFF_LO;
                return K_BYTE;
            end
            ST_OFF_LO: begin
                if (lst) return raise_fault(E_TRUNC);
                off_lo = b;
                dec_st = ST_OFF_HI;
                return K_NONE;
            end
            ST_OFF_HI: begin
                m_off = {b, off_lo};
                if (m_off == 0 || 64'(m_off) > produced || int'(m_off) > WINDOW_BYTES_DEF)
                    return raise_fault(E_OFFSET);
                if (m_nib == LEN_ESCAPE) begin
                    if (lst) return raise_fault(E_TRUNC);
                    run_left = 64'(LEN_ESCAPE) + 64'(MATCH_BASE);
                    dec_st   = ST_MATCH_EXT;
                    return K_NONE;
                end
                return open_copy(64'(m_nib) + 64'(MATCH_BASE), lst);
            end
            ST_MATCH_EXT: begin
                run_left = sat_sum(run_left, 64'(b));
                if (b == EXT_MORE) begin
                    if (lst) return raise_fault(E_TRUNC);
                    return K_NONE;
                end
                return open_copy(run_left, lst);
            end
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [KIND_BITS-1:0] copy_tick(output logic [7:0] ob);
        logic [7:0] b;
        ob = '0;
        if (dec_st != ST_COPY) return K_NONE;
        b = hist_mem[int'((produced - 64'(m_off)) % 64'(WINDOW_BYTES_DEF))];
        emit_byte(b);
        ob = b;
        run_left = run_left - 64'd1;
        if (run_left == 0) dec_st = in_ended ? ST_DONE : ST_TOKEN;
        return K_BYTE;
    endfunction

    function automatic t_out_item decode_step(input t_lz_req r);
        t_out_item res;
        logic [KIND_BITS-1:0] kind;
        logic [7:0] ob;
        kind = K_NONE;
        ob   = '0;
        if (r.op == OP_RESTART) begin
            clear_decoder();
        end else if (r.op == OP_NOP) begin
            kind = K_NONE;
        end else if (dec_st == ST_FAULT) begin
            kind = K_ERROR;
        end else if (dec_st == ST_DONE) begin
            kind = K_DONE;
        end else if (r.op == OP_PUSH) begin
            kind = (dec_st == ST_COPY) ? K_REFUSED : take_byte(r.data, r.last, ob);
        end else begin
            kind = copy_tick(ob);
        end
        res.kind          = kind;
        res.out_byte      = (kind == K_BYTE) ? ob : '0;
        res.decoded_count = produced[TOTAL_BITS-1:0];
        res.error_code    = (kind == K_ERROR) ? fault : E_NONE;
        return res;
    endfunction

    // mostly short gaps, a few long ones, none at all while in a burst
    function automatic int unsigned pick_idle(input bit burst);
        int unsigned r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(9, 30);
    endfunction

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(0, 4);
        if (r < 80) return $urandom_range(5, 14);
        if (r < 96) return $urandom_range(15, 40);
        return $urandom_range(260, 300);
    endfunction

    function automatic void put_req(input logic [OPCODE_BITS-1:0] op, input logic [7:0] d,
                                    input bit lst);
        blk_q.push_back(t_lz_req'{op: op, data: d, last: lst});
    endfunction

    function automatic void put_ext(input int unsigned rem, input bit lst);
        while (rem >= 255) begin
            put_req(OP_PUSH, EXT_MORE, 1'b0);
            rem -= 255;
        end
        put_req(OP_PUSH, 8'(rem), lst);
    endfunction

    // one compressed block, mostly well formed, sometimes cut short or corrupted
    function automatic void gen_block(input int unsigned n_seq, input logic [63:0] cap_hint);
        int unsigned prod;
        int unsigned lit;
        int unsigned mlen;
        int unsigned off;
        int unsigned k;
        int unsigned lnib;
        int unsigned mnib;
        bit end_seq;
        blk_q.delete();
        prod = 0;
        put_req(OP_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        for (int unsigned s = 0; s < n_seq; s++) begin
            end_seq = (s == n_seq - 1);
            lit = pick_len();
            if (prod == 0 && lit == 0) lit = 1;
            mlen = pick_len() + 4;
            lnib = (lit >= 15) ? 15 : lit;
            mnib = (mlen - 4 >= 15) ? 15 : mlen - 4;
            if (end_seq && $urandom_range(0, 2) != 0) begin
                // closing run of literals only
                put_req(OP_PUSH, {4'(lnib), 4'($urandom_range(0, 15))}, lit == 0);
                if (lnib == 15) put_ext(lit - 15, 1'b0);
                for (int unsigned i = 0; i < lit; i++)
                    put_req(OP_PUSH, 8'($urandom_range(0, 255)), i == lit - 1);
                prod += lit;
            end else begin
                put_req(OP_PUSH, {4'(lnib), 4'(mnib)}, 1'b0);
                if (lnib == 15) put_ext(lit - 15, 1'b0);
                for (int unsigned i = 0; i < lit; i++)
                    put_req(OP_PUSH, 8'($urandom_range(0, 255)), 1'b0);
                prod += lit;
                off = $urandom_range(1, (prod > 65535) ? 65535 : prod);
                if ($urandom_range(0, 99) < 4)
                    off = $urandom_range(0, 1) ? 0 : prod + $urandom_range(1, 50);
                if (off > 65535) off = 65535;
                put_req(OP_PUSH, off[7:0], 1'b0);
                put_req(OP_PUSH, off[15:8], end_seq && mnib != 15);
                if (mnib == 15) put_ext(mlen - 19, end_seq);
                for (int unsigned i = 0; i < mlen; i++) begin
                    if ($urandom_range(0, 99) < 5)
                        put_req(OP_PUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    put_req(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                prod += mlen;
            end
            if (64'(prod) > cap_hint) break;
        end
        // cut the block short with an early last byte
        if ($urandom_range(0, 99) < 8 && blk_q.size() > 2) begin
            k = $urandom_range(1, blk_q.size() - 1);
            while (k < blk_q.size() && blk_q[k].op != OP_PUSH) k++;
            if (k < blk_q.size()) begin
                blk_q[k].last = 1'b1;
                blk_q = blk_q[0:k];
            end
        end
        for (int unsigned i = $urandom_range(0, 2); i > 0; i--)
            put_req(2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        foreach (blk_q[i]) begin
            if ($urandom_range(0, 99) < 3) begin
                req_q.push_back(t_lz_req'{op: $urandom_range(0, 1) ? OP_NOP : OP_TICK,
                                          data: 8'($urandom_range(0, 255)),
                                          last: 1'($urandom_range(0, 1))});
                rand_items++;
            end
            req_q.push_back(blk_q[i]);
            rand_items++;
        end
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (req_q.size() != 0 || req_valid || result_q.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cap_reg = 64'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned target, input int unsigned max_seq);
        rand_items = 0;
        while (rand_items < target)
            gen_block($urandom_range(1, max_seq), cap_reg);
    endtask

    // driver: one request per handshake, random gaps between them
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (req_valid && in_ch.ready)
                result_q.push_back(decode_step(cur_req));
            if ($urandom_range(0, 99) == 0) src_burst = !src_burst;
            if (!req_valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    cur_req = req_q.pop_front();
                    req_valid <= 1'b1;
                    req_op    <= cur_req.op;
                    req_data  <= cur_req.data;
                    req_last  <= cur_req.last;
                    gap_left = pick_idle(src_burst);
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && res_ready) begin
                got.kind          = out_ch.kind;
                got.out_byte      = out_ch.out_byte;
                got.decoded_count = out_ch.decoded_count;
                got.error_code    = out_ch.error_code;
                if (result_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt < 100)
                        $display("%0t: unexpected result kind %0d byte %h count %0d err %0d",
                                 $time, got.kind, got.out_byte, got.decoded_count,
                                 got.error_code);
                end else begin
                    want = result_q.pop_front();
                    if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                        got.decoded_count !== want.decoded_count ||
                        got.error_code !== want.error_code) begin
                        err_cnt++;
                        if (err_cnt < 100)
                            $display({"%0t: mismatch expected kind %0d byte %h count %0d ",
                                      "err %0d, got kind %0d byte %h count %0d err %0d"},
                                     $time, want.kind, want.out_byte, want.decoded_count,
                                     want.error_code, got.kind, got.out_byte,
                                     got.decoded_count, got.error_code);
                    end
                end
            end
            if ($urandom_range(0, 127) == 0) snk_burst = !snk_burst;
            if (stall_left > 0) begin
                stall_left--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
                if ($urandom_range(0, 99) < 20) stall_left = pick_idle(snk_burst);
            end
        end
    end

    initial begin
        clear_decoder();
        cap_reg = 64'hFFFF_FFFF;

        // directed opening: copy with refused push, idle tick, done, truncation, bad offset
        blk_q.delete();
        put_req(OP_RESTART, 8'h00, 1'b0);
        put_req(OP_PUSH, 8'h20, 1'b0);
        put_req(OP_PUSH, 8'h00, 1'b0);
        put_req(OP_PUSH, 8'hFF, 1'b0);
        put_req(OP_PUSH, 8'h01, 1'b0);
        put_req(OP_PUSH, 8'h00, 1'b0);
        put_req(OP_TICK, 8'hFF, 1'b1);
        put_req(OP_PUSH, 8'h55, 1'b0);
        put_req(OP_TICK, 8'h00, 1'b0);
        put_req(OP_TICK, 8'h00, 1'b0);
        put_req(OP_TICK, 8'h00, 1'b0);
        put_req(OP_TICK, 8'h00, 1'b0);
        put_req(OP_NOP, 8'hFF, 1'b1);
        put_req(OP_PUSH, 8'h00, 1'b1);
        put_req(OP_PUSH, 8'hA5, 1'b0);
        put_req(OP_TICK, 8'h00, 1'b0);
        put_req(OP_RESTART, 8'hFF, 1'b1);
        put_req(OP_PUSH, 8'hF0, 1'b1);
        put_req(OP_TICK, 8'h00, 1'b0);
        put_req(OP_RESTART, 8'h00, 1'b0);
        put_req(OP_PUSH, 8'h10, 1'b0);
        put_req(OP_PUSH, 8'h80, 1'b0);
        put_req(OP_PUSH, 8'h00, 1'b0);
        put_req(OP_PUSH, 8'h00, 1'b0);
        put_req(OP_RESTART, 8'h00, 1'b0);
        foreach (blk_q[i]) req_q.push_back(blk_q[i]);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        run_phase(350, 8);
        wait_drained();
        write_capacity(32'd0);
        @(negedge clk);
        run_phase(80, 2);
        wait_drained();
        write_capacity(32'd1);
        @(negedge clk);
        run_phase(100, 2);
        wait_drained();
        write_capacity(32'd24);
        @(negedge clk);
        run_phase(150, 3);
        wait_drained();
        write_capacity(32'd150);
        @(negedge clk);
        run_phase(220, 6);
        wait_drained();
        write_capacity(32'($urandom_range(300, 3000)));
        @(negedge clk);
        run_phase(250, 8);
        wait_drained();
        write_capacity($urandom());
        @(negedge clk);
        run_phase(150, 8);
        wait_drained();
        write_capacity(32'hFFFF_FFFF);
        @(negedge clk);
        run_phase(150, 8);
        wait_drained();

        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
